// ===== design/lsf_pkg.sv =====
// Shared types and constants for the smallest-factor sieve.
package lsf_pkg;

  localparam int unsigned NUM_W    = 17;
  localparam int unsigned FACTOR_W = 16;
  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned PROD_W   = 2 * FACTOR_W;

  // first integer handled after a clear
  localparam logic [NUM_W-1:0] FIRST_NUM = NUM_W'(2);

  // controller to datapath
  typedef struct packed {
    logic clr_start;  // reset count and next number, start sweep at entry 0
    logic clr_step;   // zero one table entry
    logic rd_fact;    // read table entry of the current number
    logic take_fact;  // latch factor, record a new prime
    logic rd_prime;   // read prime list at walk index
    logic mul;        // register number * prime
    logic mark;       // write factor of the product, advance walk index
    logic ld_out;     // load the result register
  } lsf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;   // sweep at the last entry
    logic beyond;     // current number exceeds the effective limit
    logic walk_done;  // walk index reached the prime count
    logic stop;       // prime above factor or product above limit
    logic out_free;   // result register can take a new item
  } lsf_sts_t;

endpackage

// ===== design/lsf_ctrl.sv =====
// Sequencer for the sieve: clearing sweep, table lookup and prime walk.
module lsf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              restart_i,
  output logic              in_ready_o,
  input  lsf_pkg::lsf_sts_t sts_i,
  output lsf_pkg::lsf_cmd_t cmd_o
);
  import lsf_pkg::*;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_CHECK,
    ST_FACT,
    ST_LOOP,
    ST_MUL,
    ST_TEST,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      // sweep after reset, no item pending
      ST_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (restart_i) begin
            cmd_o.clr_start = 1'b1;
            state_d = ST_CLEAR;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.beyond) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.rd_fact = 1'b1;
          state_d = ST_FACT;
        end
      end
      ST_FACT: begin
        cmd_o.take_fact = 1'b1;
        state_d = ST_LOOP;
      end
      ST_LOOP: begin
        if (sts_i.walk_done) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.rd_prime = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = ST_TEST;
      end
      ST_TEST: begin
        if (sts_i.stop) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.mark = 1'b1;
          state_d = ST_LOOP;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.ld_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // reset starts with a full clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/lsf_datapath.sv =====
// Factor table, prime list, walk registers, multiplier and result register.
module lsf_datapath #(
  parameter int unsigned MAX_VALUE   = 65536,
  parameter int unsigned PRIME_SLOTS = 8192
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lsf_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  input  lsf_pkg::lsf_cmd_t             cmd_i,
  output lsf_pkg::lsf_sts_t             sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lsf_pkg::NUM_W-1:0]     number_o,
  output logic [lsf_pkg::FACTOR_W-1:0]  smallest_factor_o,
  output logic                          is_prime_o,
  output logic                          beyond_limit_o
);
  import lsf_pkg::*;

  localparam int unsigned AW     = $clog2(MAX_VALUE);
  localparam int unsigned PW     = $clog2(PRIME_SLOTS);
  localparam int unsigned CW     = $clog2(PRIME_SLOTS + 1);
  localparam int unsigned TOP_VAL = MAX_VALUE - 1;

  logic [FACTOR_W-1:0] factor_mem [MAX_VALUE];
  logic [FACTOR_W-1:0] prime_mem  [PRIME_SLOTS];

  logic [LIMIT_W-1:0]  limit_q;
  logic [LIMIT_W-1:0]  lim_eff;
  logic [NUM_W-1:0]    num_q;
  logic [CW-1:0]       count_q;
  logic [CW-1:0]       walk_q;
  logic [AW-1:0]       clr_addr_q;
  logic [FACTOR_W-1:0] rd_q;
  logic [FACTOR_W-1:0] fact_q, fact_d;
  logic                prime_q, prime_d;
  logic [FACTOR_W-1:0] p_q;
  logic [PROD_W-1:0]   m_q;
  logic                out_valid_q;
  logic                beyond;

  assign lim_eff = (32'(limit_q) > TOP_VAL) ? LIMIT_W'(TOP_VAL) : limit_q;
  assign beyond  = num_q > {1'b0, lim_eff};

  assign prime_d = (rd_q == '0);
  assign fact_d  = prime_d ? num_q[FACTOR_W-1:0] : rd_q;

  assign sts_o.clr_last  = (clr_addr_q == AW'(TOP_VAL));
  assign sts_o.beyond    = beyond;
  assign sts_o.walk_done = (walk_q >= count_q);
  assign sts_o.stop      = (p_q > fact_q) || (m_q > PROD_W'(lim_eff));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= LIMIT_W'(65535);
      num_q      <= FIRST_NUM;
      count_q    <= '0;
      walk_q     <= '0;
      clr_addr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (cmd_i.clr_start) begin
        num_q      <= FIRST_NUM;
        count_q    <= '0;
        clr_addr_q <= '0;
      end
      if (cmd_i.clr_step) clr_addr_q <= clr_addr_q + AW'(1);
      if (cmd_i.take_fact) begin
        walk_q <= '0;
        if (prime_d && (count_q < CW'(PRIME_SLOTS))) count_q <= count_q + CW'(1);
      end
      if (cmd_i.mark) walk_q <= walk_q + CW'(1);
      if (cmd_i.ld_out) begin
        out_valid_q <= 1'b1;
        if (!beyond) num_q <= num_q + NUM_W'(1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // one write per cycle: sweep, own factor of a prime, or a marked multiple
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      factor_mem[clr_addr_q] <= '0;
    end else if (cmd_i.take_fact && prime_d) begin
      factor_mem[AW'(num_q)] <= num_q[FACTOR_W-1:0];
    end else if (cmd_i.mark) begin
      factor_mem[AW'(m_q)] <= p_q;
    end
    if (cmd_i.rd_fact) rd_q <= factor_mem[AW'(num_q)];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_fact && prime_d && (count_q < CW'(PRIME_SLOTS))) begin
      prime_mem[count_q[PW-1:0]] <= num_q[FACTOR_W-1:0];
    end
    if (cmd_i.rd_prime) p_q <= prime_mem[walk_q[PW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_fact) begin
      fact_q  <= fact_d;
      prime_q <= prime_d;
    end
    if (cmd_i.mul) m_q <= PROD_W'(num_q[FACTOR_W-1:0]) * PROD_W'(p_q);
    if (cmd_i.ld_out) begin
      number_o          <= num_q;
      smallest_factor_o <= beyond ? '0 : fact_q;
      is_prime_o        <= beyond ? 1'b0 : prime_q;
      beyond_limit_o    <= beyond;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/linear_sieve_smallest_factor.sv =====
// Linear sieve: per item, smallest prime factor of the next integer.
// Each item reads its table entry, then walks the prime list, marking one multiple
// per iteration until the walk runs out or a test ends it; past the limit both are
// skipped. A held result stalls the last step; no new item is taken until it loads.
// Reset and each restart item run a clearing sweep over all MAX_VALUE table entries.
// Reset sets limit to 65535, the prime count to zero and the next integer to 2.
module linear_sieve_smallest_factor #(
  parameter int unsigned MAX_VALUE   = 65536,
  parameter int unsigned PRIME_SLOTS = 8192
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lsf_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          restart_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lsf_pkg::NUM_W-1:0]     number_o,
  output logic [lsf_pkg::FACTOR_W-1:0]  smallest_factor_o,
  output logic                          is_prime_o,
  output logic                          beyond_limit_o
);
  import lsf_pkg::*;

  lsf_cmd_t cmd;
  lsf_sts_t sts;

  lsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .restart_i  (restart_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lsf_datapath #(
    .MAX_VALUE   (MAX_VALUE),
    .PRIME_SLOTS (PRIME_SLOTS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .number_o          (number_o),
    .smallest_factor_o (smallest_factor_o),
    .is_prime_o        (is_prime_o),
    .beyond_limit_o    (beyond_limit_o)
  );

endmodule
